### rtl/core/jacn_pkg.sv
// Package with the shared types and constants of the joystick axis calibration block.
`default_nettype none

package jacn_pkg;

  // Sample and result widths.
  localparam int SampleBits = 12;
  localparam int PctBits    = 7;
  localparam int ProdBits   = SampleBits + PctBits;
  localparam int QuotSteps  = PctBits;
  localparam int StepBits   = 3;
  localparam int DshBits    = SampleBits + QuotSteps - 1;

  localparam logic [PctBits-1:0] PercentFull = 7'd100;

  // Calibration values after reset.
  localparam logic [SampleBits-1:0] XLowestReset  = 12'd842;
  localparam logic [SampleBits-1:0] XHighestReset = 12'd3223;
  localparam logic [SampleBits-1:0] YLowestReset  = 12'd853;
  localparam logic [SampleBits-1:0] YHighestReset = 12'd2840;

  // Depth of the queue between front and back.
  localparam int FifoDepth   = 2;
  localparam int FifoPtrBits = 1;
  localparam int FifoCntBits = 2;

  // One input request.
  typedef struct packed {
    logic                  mode;
    logic [SampleBits-1:0] x_raw;
    logic [SampleBits-1:0] y_raw;
    logic                  button_level;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [PctBits-1:0] x_percent;
    logic [PctBits-1:0] y_percent;
    logic               press_event;
    logic               button_pressed;
  } out_item_t;

  // How the back end has to treat one axis.
  typedef enum logic [1:0] {
    AXIS_ZERO,
    AXIS_FULL,
    AXIS_DIV
  } axis_kind_e;

  typedef struct packed {
    axis_kind_e            kind;
    logic [SampleBits-1:0] num;
    logic [SampleBits-1:0] den;
  } axis_op_t;

  // Classified work handed from front to back.
  typedef struct packed {
    axis_op_t x;
    axis_op_t y;
    logic     press_event;
    logic     button_pressed;
  } work_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_e;

endpackage

`default_nettype wire

### rtl/core/jacn_fifo.sv
// Two-entry queue that carries classified work from the front to the back.
`default_nettype none

module jacn_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire jacn_pkg::work_t data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output jacn_pkg::work_t      data_o,
  output logic                 empty_o
);
  import jacn_pkg::*;

  work_t                  mem_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntBits-1:0] cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntBits'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jacn_front.sv
// Front end: accepts requests, widens the calibration range and classifies each axis.
`default_nettype none

module jacn_front (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_valid_i,
  input  wire                     cfg_data_i,
  input  wire                     push_i,
  input  wire jacn_pkg::in_item_t in_item_i,
  input  wire                     q_full_i,
  output logic                    q_push_o,
  output jacn_pkg::work_t         q_data_o
);
  import jacn_pkg::*;

  logic [SampleBits-1:0] x_lo_q, x_lo_d, x_hi_q, x_hi_d;
  logic [SampleBits-1:0] y_lo_q, y_lo_d, y_hi_q, y_hi_d;
  logic                  level_q;
  logic                  prev_q;
  logic                  accept;
  logic                  pressed;

  // Sorts one axis into at or below range (or an empty range), at or above range, or a real division.
  function automatic axis_op_t classify(input logic [SampleBits-1:0] raw,
                                        input logic [SampleBits-1:0] lo,
                                        input logic [SampleBits-1:0] hi);
    axis_op_t op;
    op.kind = AXIS_DIV;
    op.num  = raw - lo;
    op.den  = hi - lo;
    if (hi <= lo || raw <= lo) begin
      op.kind = AXIS_ZERO;
    end else if (raw >= hi) begin
      op.kind = AXIS_FULL;
    end
    return op;
  endfunction

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign pressed  = (in_item_i.button_level == level_q);

  // In calibrate mode the range takes in the new sample first.
  always_comb begin
    x_lo_d = x_lo_q;
    x_hi_d = x_hi_q;
    y_lo_d = y_lo_q;
    y_hi_d = y_hi_q;
    if (in_item_i.mode) begin
      if (in_item_i.x_raw < x_lo_q) x_lo_d = in_item_i.x_raw;
      if (in_item_i.x_raw > x_hi_q) x_hi_d = in_item_i.x_raw;
      if (in_item_i.y_raw < y_lo_q) y_lo_d = in_item_i.y_raw;
      if (in_item_i.y_raw > y_hi_q) y_hi_d = in_item_i.y_raw;
    end
  end

  // Work handed to the queue.
  always_comb begin
    q_data_o.x              = classify(in_item_i.x_raw, x_lo_d, x_hi_d);
    q_data_o.y              = classify(in_item_i.y_raw, y_lo_d, y_hi_d);
    q_data_o.press_event    = !prev_q && pressed;
    q_data_o.button_pressed = pressed;
  end

  // Calibration, button history and the pressed-level register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lo_q  <= XLowestReset;
      x_hi_q  <= XHighestReset;
      y_lo_q  <= YLowestReset;
      y_hi_q  <= YHighestReset;
      prev_q  <= 1'b0;
      level_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        level_q <= cfg_data_i;
      end
      if (accept) begin
        x_lo_q <= x_lo_d;
        x_hi_q <= x_hi_d;
        y_lo_q <= y_lo_d;
        y_hi_q <= y_hi_d;
        prev_q <= pressed;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/jacn_div.sv
// Restoring divider that turns one axis offset into a percent, one quotient bit a cycle.
`default_nettype none

module jacn_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire jacn_pkg::axis_op_t          op_i,
  input  wire                              ack_i,
  output logic                             done_o,
  output logic [jacn_pkg::PctBits-1:0]     quot_o
);
  import jacn_pkg::*;

  logic                busy_q, done_q;
  logic [StepBits-1:0] step_q;
  logic [ProdBits-1:0] rem_q;
  logic [DshBits-1:0]  dsh_q;
  logic [PctBits-1:0]  quot_q;
  logic [ProdBits-1:0] prod;
  logic                ge;

  assign done_o = done_q;
  assign quot_o = quot_q;

  // Offset times one hundred is the dividend.
  assign prod = ProdBits'(op_i.num) * ProdBits'(PercentFull);
  assign ge   = (rem_q >= ProdBits'(dsh_q));

  // Control: busy while quotient bits remain, done until the back takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepBits'(QuotSteps - 1);
      busy_q <= (op_i.kind == AXIS_DIV);
      done_q <= (op_i.kind != AXIS_DIV);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (ack_i) begin
      done_q <= 1'b0;
    end
  end

  // Datapath: trial subtract of the shifted divisor, quotient shifts in from the right.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= prod;
      dsh_q <= {op_i.den, {(QuotSteps - 1){1'b0}}};
      unique case (op_i.kind)
        AXIS_FULL: quot_q <= PercentFull;
        AXIS_ZERO: quot_q <= '0;
        AXIS_DIV:  quot_q <= '0;
        default:   quot_q <= '0;
      endcase
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - ProdBits'(dsh_q);
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[PctBits-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/core/jacn_back.sv
// Back end: takes work from the queue, runs both axis dividers and holds the result.
`default_nettype none

module jacn_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_empty_i,
  input  wire jacn_pkg::work_t q_data_i,
  output logic                 q_pop_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output jacn_pkg::out_item_t  out_item_o
);
  import jacn_pkg::*;

  back_state_e        state_q, state_d;
  logic               start, ack;
  logic               x_done, y_done;
  logic [PctBits-1:0] x_quot, y_quot;
  logic               event_q, pressed_q;
  logic               out_valid_q;
  out_item_t          out_q;

  jacn_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (q_data_i.x),
    .ack_i  (ack),
    .done_o (x_done),
    .quot_o (x_quot)
  );

  jacn_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (q_data_i.y),
    .ack_i  (ack),
    .done_o (y_done),
    .quot_o (y_quot)
  );

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;
  assign q_pop_o    = start;

  // Next state: start on queued work, finish once both axes are done and the output is free.
  always_comb begin
    state_d = state_q;
    start   = 1'b0;
    ack     = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (!q_empty_i) begin
          start   = 1'b1;
          state_d = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (x_done && y_done && (!out_valid_q || pop_i)) begin
          ack     = 1'b1;
          state_d = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ack) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Button flags ride along with the division; the result register loads at the end.
  always_ff @(posedge clk_i) begin
    if (start) begin
      event_q   <= q_data_i.press_event;
      pressed_q <= q_data_i.button_pressed;
    end
    if (ack) begin
      out_q.x_percent      <= x_quot;
      out_q.y_percent      <= y_quot;
      out_q.press_event    <= event_q;
      out_q.button_pressed <= pressed_q;
    end
  end

endmodule

`default_nettype wire

### rtl/core/joystick_axis_calibrate_normalize.sv
// Top level of the joystick axis calibration and percent normalization block.
`default_nettype none

// Each request carries an X/Y sample pair, the button pin level and a mode. In
// calibrate mode the stored per-axis minimum and maximum widen first; in both
// modes each axis is reported as (raw - min) * 100 / (max - min), rounded down
// and clamped to 0..100, together with the button state and a press edge flag.
// The front end takes one request per cycle, unless the queue is full, into a
// two-entry queue. The back end handles one request at a time: a request
// whose two samples both lie at or beyond an end of their ranges needs no
// division, otherwise the axes go through restoring dividers that produce one
// quotient bit per cycle; that divider sets the sustained rate. One finished
// result is held on the output while the next one is being computed. The
// pressed-level register is written through the cfg channel, which is always
// ready, and should only be changed while no request is in flight.

module joystick_axis_calibrate_normalize (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire                     cfg_data_i,
  input  wire                     push,
  output logic                    full,
  input  wire jacn_pkg::in_item_t in_item_i,
  output logic                    empty,
  input  wire                     pop,
  output jacn_pkg::out_item_t     out_item_o
);
  import jacn_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  work_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  jacn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  jacn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  jacn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_item_o(out_item_o)
  );

endmodule

`default_nettype wire
